>>> rtl/ubds_pkg.sv
// ubds_pkg: shared types and constants of the uart baud divisor search block
// depends on nothing; imported by every module of the block
`default_nettype none

package ubds_pkg;

    localparam int OSR_MAX_DEF = 31;
    localparam int OSR_MIN_DEF = 3;

    localparam int BAUD_W  = 32;
    localparam int CLK_W   = 32;
    localparam int OSR_W   = 5;
    localparam int RATIO_W = OSR_W + 1;
    localparam int SBR_W   = 16;
    localparam int DVS_W   = BAUD_W + RATIO_W;
    localparam int OUT_W   = 56;

    localparam logic [CLK_W-1:0] CLK_RESET = 32'd8000000;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_REJECT = 2'd1,
        ST_NONE   = 2'd2
    } ubds_status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SBR_START,
        S_SBR_WAIT,
        S_RATE_START,
        S_RATE_WAIT,
        S_NEXT,
        S_DONE
    } ubds_state_t;

    typedef struct packed {
        logic [BAUD_W-1:0] rate;
        logic [SBR_W-1:0]  sbr;
        logic [OSR_W-1:0]  osr;
        ubds_status_t      status;
    } ubds_result_t;

endpackage

`default_nettype wire

>>> rtl/ubds_divider.sv
// ubds_divider: restoring serial divider, one quotient bit per cycle
// 32-bit dividend, 38-bit divisor; uses ubds_pkg
`default_nettype none

module ubds_divider
    import ubds_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              start,
    input  wire logic [CLK_W-1:0]  dividend,
    input  wire logic [DVS_W-1:0]  divisor,
    output logic                   done,
    output logic [CLK_W-1:0]       quotient
);

    localparam int CNT_W = $clog2(CLK_W);

    logic [DVS_W-1:0] rem_reg, rem_next;
    logic [CLK_W-1:0] quo_reg, quo_next;
    logic [DVS_W-1:0] dvs_reg, dvs_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DVS_W:0]   trial;
    logic             fits;

    always_comb begin
        trial = {rem_reg, quo_reg[CLK_W-1]};
        fits  = trial >= {1'b0, dvs_reg};
    end

    always_comb begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            // remainder stays below the divisor, so the low bits hold it
            rem_next = fits ? DVS_W'(trial - {1'b0, dvs_reg}) : trial[DVS_W-1:0];
            quo_next = {quo_reg[CLK_W-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(CLK_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

>>> rtl/ubds_search.sv
// ubds_search: sequencer over the oversampling ratios with one multiplier
// and the shared serial divider; keeps the best candidate; uses ubds_pkg, ubds_divider
`default_nettype none

module ubds_search
    import ubds_pkg::*;
#(
    parameter int OSR_MAX = OSR_MAX_DEF,
    parameter int OSR_MIN = OSR_MIN_DEF
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              start,
    input  wire logic [BAUD_W-1:0] baud,
    input  wire logic [CLK_W-1:0]  clk_hz,
    output logic                   idle,
    output logic                   res_valid,
    input  wire logic              res_ready,
    output ubds_result_t           res
);

    ubds_state_t       state_reg, state_next;
    logic [OSR_W-1:0]  osr_reg, osr_next;
    logic [BAUD_W-1:0] baud_reg, baud_next;
    logic [CLK_W-1:0]  clk_reg, clk_next;
    logic [SBR_W-1:0]  sbr_reg, sbr_next;
    logic [BAUD_W-1:0] best_diff_reg, best_diff_next;
    logic [OSR_W-1:0]  best_osr_reg, best_osr_next;
    logic [SBR_W-1:0]  best_sbr_reg, best_sbr_next;
    logic [BAUD_W-1:0] best_rate_reg, best_rate_next;
    logic              found_reg, found_next;
    logic              reject_reg, reject_next;

    logic              reject;
    logic [RATIO_W-1:0] ratio;
    logic [DVS_W-1:0]  mul_b;
    logic [DVS_W-1:0]  product;
    logic              div_start;
    logic              div_done;
    logic [CLK_W-1:0]  quotient;
    logic              sbr_bad;
    logic [BAUD_W-1:0] diff;
    logic              better;

    assign reject  = (baud == '0) || (baud > (clk_hz >> 2));
    assign ratio   = {1'b0, osr_reg} + RATIO_W'(1);
    // one multiplier: ratio*baud for the divisor, ratio*sbr for the rate
    assign mul_b   = (state_reg == S_SBR_START) ? DVS_W'(baud_reg) : DVS_W'(sbr_reg);
    assign product = DVS_W'(DVS_W'(ratio) * mul_b);
    assign sbr_bad = (quotient == '0) || (quotient[CLK_W-1:SBR_W] != '0);
    // achieved rate is never below the request
    assign diff    = quotient - baud_reg;
    assign better  = diff < best_diff_reg;

    ubds_divider u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (clk_reg),
        .divisor  (product),
        .done     (div_done),
        .quotient (quotient)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (start) begin
                    state_next = reject ? S_DONE : S_SBR_START;
                end
            end
            S_SBR_START: state_next = S_SBR_WAIT;
            S_SBR_WAIT: begin
                if (div_done) begin
                    state_next = sbr_bad ? S_NEXT : S_RATE_START;
                end
            end
            S_RATE_START: state_next = S_RATE_WAIT;
            S_RATE_WAIT: begin
                if (div_done) begin
                    state_next = (better && diff == '0) ? S_DONE : S_NEXT;
                end
            end
            S_NEXT: begin
                state_next = (osr_reg == OSR_W'(OSR_MIN)) ? S_DONE : S_SBR_START;
            end
            S_DONE: begin
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // datapath registers
    always_comb begin
        osr_next       = osr_reg;
        baud_next      = baud_reg;
        clk_next       = clk_reg;
        sbr_next       = sbr_reg;
        best_diff_next = best_diff_reg;
        best_osr_next  = best_osr_reg;
        best_sbr_next  = best_sbr_reg;
        best_rate_next = best_rate_reg;
        found_next     = found_reg;
        reject_next    = reject_reg;
        case (state_reg)
            S_IDLE: begin
                if (start) begin
                    baud_next      = baud;
                    clk_next       = clk_hz;
                    osr_next       = OSR_W'(OSR_MAX);
                    best_diff_next = baud;
                    found_next     = 1'b0;
                    reject_next    = reject;
                end
            end
            S_SBR_WAIT: begin
                if (div_done) begin
                    sbr_next = quotient[SBR_W-1:0];
                end
            end
            S_RATE_WAIT: begin
                if (div_done && better) begin
                    best_diff_next = diff;
                    best_osr_next  = osr_reg;
                    best_sbr_next  = sbr_reg;
                    best_rate_next = quotient;
                    found_next     = 1'b1;
                end
            end
            S_NEXT: begin
                if (osr_reg != OSR_W'(OSR_MIN)) begin
                    osr_next = osr_reg - 1'b1;
                end
            end
            default: ;
        endcase
    end

    // outputs
    always_comb begin
        idle      = state_reg == S_IDLE;
        div_start = (state_reg == S_SBR_START) || (state_reg == S_RATE_START);
        res_valid = state_reg == S_DONE;
        res       = '0;
        if (reject_reg) begin
            res.status = ST_REJECT;
        end else if (!found_reg) begin
            res.status = ST_NONE;
        end else begin
            res.status = ST_OK;
            res.osr    = best_osr_reg;
            res.sbr    = best_sbr_reg;
            res.rate   = best_rate_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            found_reg  <= 1'b0;
            reject_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            found_reg  <= found_next;
            reject_reg <= reject_next;
        end
        osr_reg       <= osr_next;
        baud_reg      <= baud_next;
        clk_reg       <= clk_next;
        sbr_reg       <= sbr_next;
        best_diff_reg <= best_diff_next;
        best_osr_reg  <= best_osr_next;
        best_sbr_reg  <= best_sbr_next;
        best_rate_reg <= best_rate_next;
    end

`ifndef SYNTHESIS
    a_ok_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid && res.status == ST_OK |-> res.sbr != '0 && res.osr >= OSR_W'(OSR_MIN))
        else $error("ok result with empty divisor or ratio below range");

    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid && res.status != ST_OK |-> res.osr == '0 && res.sbr == '0 && res.rate == '0)
        else $error("failed result carries nonzero fields");

    a_done_waits: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> state_reg == S_SBR_WAIT || state_reg == S_RATE_WAIT)
        else $error("divider finished outside a wait state");

    a_start_leaves: assert property (@(posedge aclk) disable iff (!aresetn)
        idle && start |=> !idle)
        else $error("accepted request did not start a search");
`endif

endmodule

`default_nettype wire

>>> rtl/uart_baud_divisor_search_top.sv
// flow: a rejected request goes straight to the done state and m_tvalid rises from the
// registered output; a search runs per oversampling ratio two divisions on the one serial
// divider plus sequencing, only the first when the divisor is out of range, and the result
// comes sooner on an early exact match
// throughput: one request at a time; the next is taken once the result beat has left
// reset: aresetn synchronous active low, clock_hz returns to 8000000, no result pending
`default_nettype none

module uart_baud_divisor_search_top
    import ubds_pkg::*;
#(
    parameter int OSR_MAX = OSR_MAX_DEF,
    parameter int OSR_MIN = OSR_MIN_DEF
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [BAUD_W-1:0] s_tdata,   // [31:0] baud_rate
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [OUT_W-1:0]       m_tdata,   // [1:0] status, [6:2] osr_value,
                                              // [22:7] sbr_value, [54:23] achieved_baud
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [CLK_W-1:0]  cfg_data   // clock_hz
);

    logic [CLK_W-1:0] clk_hz_reg, clk_hz_next;
    logic             m_tvalid_reg, m_tvalid_next;
    logic [OUT_W-1:0] m_tdata_reg, m_tdata_next;

    logic         idle;
    logic         res_valid;
    logic         res_ready;
    ubds_result_t res;

    assign cfg_ready = 1'b1;
    assign s_tready  = idle && !m_tvalid_reg;
    assign res_ready = !m_tvalid_reg;

    ubds_search #(
        .OSR_MAX (OSR_MAX),
        .OSR_MIN (OSR_MIN)
    ) u_search (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (s_tvalid && s_tready),
        .baud      (s_tdata),
        .clk_hz    (clk_hz_reg),
        .idle      (idle),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    always_comb begin
        clk_hz_next   = cfg_valid ? cfg_data : clk_hz_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end
        if (res_valid && res_ready) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = OUT_W'(res);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clk_hz_reg   <= CLK_RESET;
            m_tvalid_reg <= 1'b0;
        end else begin
            clk_hz_reg   <= clk_hz_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire
